// ===== hw/rtl/dic_pkg.sv =====
// Shared types and constants for the dynamic inversion counter.
package dic_pkg;

    // Item value width and result field widths
    localparam int VAL_W     = 11;
    localparam int OP_W      = 2;
    localparam int CNT_OUT_W = 19;
    localparam logic [CNT_OUT_W-1:0] CNT_MAX = '1;

    // Operation codes carried on the input tuser
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

    // Result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Status from the position scanner to the controller
    typedef struct packed {
        logic done;
        logic key_present;
    } scan_stat_t;

endpackage

// ===== hw/rtl/dic_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dic_scan.sv =====
// Position scanner: walks the loaded positions and counts inversions against a key.
module dic_scan #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              del_mode,
    input  logic [dic_pkg::VAL_W-1:0]         key,
    input  logic [$clog2(MAX_ITEMS)-1:0]      key_pos,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    limit,
    output logic                              rd_en,
    output logic [$clog2(MAX_ITEMS)-1:0]      rd_addr,
    input  logic [dic_pkg::VAL_W:0]           rd_data,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    formed,
    output dic_pkg::scan_stat_t               stat
);
    import dic_pkg::*;

    localparam int POS_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS+1);

    logic             active_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             pend_reg;
    logic [POS_W-1:0] pidx_reg;
    logic [CNT_W-1:0] formed_reg;
    logic             keypres_reg;

    logic             more;
    logic             ent_present;
    logic [VAL_W-1:0] ent_val;
    logic             hit;
    logic             is_key;

    assign more    = issue_reg < limit;
    assign rd_en   = active_reg && more;
    assign rd_addr = issue_reg[POS_W-1:0];

    // Compare the entry returned by the position memory
    assign ent_present = rd_data[VAL_W];
    assign ent_val     = rd_data[VAL_W-1:0];
    assign is_key      = del_mode && (pidx_reg == key_pos);
    always_comb
    begin
        if (del_mode)
        begin
            hit = ((pidx_reg < key_pos) && (ent_val > key)) ||
                  ((pidx_reg > key_pos) && (ent_val < key));
        end
        else
        begin
            hit = ent_val > key;
        end
    end

    // Issue one read a cycle, accumulate one compare a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            formed_reg  <= '0;
            keypres_reg <= 1'b0;
        end
        else if (start)
        begin
            active_reg  <= 1'b1;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            formed_reg  <= '0;
            keypres_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            pend_reg <= more;
            if (more)
            begin
                pidx_reg  <= issue_reg[POS_W-1:0];
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (pend_reg)
            begin
                if (is_key)
                begin
                    keypres_reg <= ent_present;
                end
                else if (ent_present && hit)
                begin
                    formed_reg <= formed_reg + CNT_W'(1);
                end
            end
            if (!more && !pend_reg)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign formed           = formed_reg;
    assign stat.done        = active_reg && !more && !pend_reg;
    assign stat.key_present = keypres_reg;

endmodule

// ===== hw/rtl/dynamic_inversion_counter_unit.sv =====
// Dynamic inversion counter top level: command FSM, value and position memories.
// One item at a time. Append or delete: the result follows a scan of the loaded positions,
// one entry a cycle. Range or opcode errors answer from the idle state; duplicate, unseen
// or full after the check; an already deleted value after the full scan. Clear answers after
// sweeping min(MAX_ITEMS, 2047) value entries.
// Reset is asynchronous; after reset the same sweep runs with s_tready low.
module dynamic_inversion_counter_unit #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] inversion_count
    output logic [0:0]  m_tuser    // [0] status
);
    import dic_pkg::*;

    localparam int POS_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS+1);
    localparam int TOT_W  = (2*CNT_W > 20) ? 2*CNT_W : 20;
    localparam int VDEPTH = (MAX_ITEMS < 2047) ? MAX_ITEMS : 2047;
    localparam int VIDX_W = $clog2(VDEPTH);
    localparam logic [31:0] MAX_L = 32'(MAX_ITEMS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [VIDX_W-1:0]    sweep_reg, sweep_next;
    logic                 clr_emit_reg, clr_emit_next;
    logic [CNT_OUT_W-1:0] res_count_reg, res_count_next;
    logic                 res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CNT_OUT_W-1:0] m_count_reg, m_count_next;
    logic                 m_status_reg, m_status_next;

    logic                 accept;
    logic [VAL_W-1:0]     in_val;
    logic [OP_W-1:0]      in_op;
    logic                 in_bad;
    logic [VAL_W-1:0]     in_val_m1;
    logic [VAL_W-1:0]     reg_val_m1;
    logic                 out_free;
    logic                 is_append;
    logic                 is_delete;

    logic                 vram_we;
    logic [VIDX_W-1:0]    vram_waddr;
    logic [POS_W:0]       vram_wdata;
    logic [POS_W:0]       vram_rdata;
    logic                 seen;
    logic [POS_W-1:0]     seen_pos;

    logic                 pram_we;
    logic [POS_W-1:0]     pram_waddr;
    logic [VAL_W:0]       pram_wdata;
    logic                 pram_re;
    logic [POS_W-1:0]     pram_raddr;
    logic [VAL_W:0]       pram_rdata;

    logic                 scan_start;
    logic [CNT_W-1:0]     formed;
    scan_stat_t           scan_stat;
    logic [TOT_W-1:0]     formed_ext;
    logic [TOT_W-1:0]     sum_tot;
    logic [TOT_W-1:0]     diff_tot;
    logic                 chk_err;

    function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [TOT_W-1:0] t);
        logic [CNT_OUT_W-1:0] r;
        r = (t > TOT_W'(CNT_MAX)) ? CNT_MAX : t[CNT_OUT_W-1:0];
        return r;
    endfunction

    // Decode the input transfer
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_val     = s_tdata[VAL_W-1:0];
    assign in_op      = s_tuser;
    assign in_val_m1  = in_val - VAL_W'(1);
    assign reg_val_m1 = val_reg - VAL_W'(1);
    assign in_bad     = (in_op == OP_BAD) || (in_val == '0) || (32'(in_val) > MAX_L);
    assign is_append  = (op_reg == OP_APPEND);
    assign is_delete  = (op_reg == OP_DELETE);
    assign out_free   = !m_valid_reg || m_tready;

    // Value memory: per value, seen flag and position
    assign seen     = vram_rdata[POS_W];
    assign seen_pos = vram_rdata[POS_W-1:0];

    assign vram_we    = (state_reg == ST_CLEAR) ||
                        ((state_reg == ST_SCAN) && scan_stat.done && is_append);
    assign vram_waddr = (state_reg == ST_CLEAR) ? sweep_reg : reg_val_m1[VIDX_W-1:0];
    assign vram_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, loaded_reg[POS_W-1:0]};

    dic_ram #(
        .WIDTH (POS_W + 1),
        .DEPTH (VDEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (accept),
        .raddr (in_val_m1[VIDX_W-1:0]),
        .rdata (vram_rdata)
    );

    // Position memory: per position, present flag and value
    assign pram_we    = (state_reg == ST_SCAN) && scan_stat.done &&
                        (is_append || (is_delete && scan_stat.key_present));
    assign pram_waddr = is_append ? loaded_reg[POS_W-1:0] : pos_reg;
    assign pram_wdata = {is_append, val_reg};

    dic_ram #(
        .WIDTH (VAL_W + 1),
        .DEPTH (MAX_ITEMS)
    ) u_position_ram (
        .clk   (clk),
        .we    (pram_we),
        .waddr (pram_waddr),
        .wdata (pram_wdata),
        .re    (pram_re),
        .raddr (pram_raddr),
        .rdata (pram_rdata)
    );

    // Scan the loaded positions
    assign chk_err    = is_append ? (seen || (loaded_reg == CNT_W'(MAX_ITEMS))) : !seen;
    assign scan_start = (state_reg == ST_CHECK) && !chk_err;

    dic_scan #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .del_mode (is_delete),
        .key      (val_reg),
        .key_pos  (pos_reg),
        .limit    (loaded_reg),
        .rd_en    (pram_re),
        .rd_addr  (pram_raddr),
        .rd_data  (pram_rdata),
        .formed   (formed),
        .stat     (scan_stat)
    );

    assign formed_ext = TOT_W'(formed);
    assign sum_tot    = total_reg + formed_ext;
    assign diff_tot   = (formed_ext > total_reg) ? '0 : (total_reg - formed_ext);

    // Command sequencing
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        loaded_next     = loaded_reg;
        total_next      = total_reg;
        sweep_next      = sweep_reg;
        clr_emit_next   = clr_emit_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + VIDX_W'(1);
                if (sweep_reg == VIDX_W'(VDEPTH - 1))
                begin
                    sweep_next      = '0;
                    res_count_next  = '0;
                    res_status_next = STAT_OK;
                    state_next      = clr_emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    val_next = in_val;
                    if (in_op == OP_CLEAR)
                    begin
                        loaded_next   = '0;
                        total_next    = '0;
                        sweep_next    = '0;
                        clr_emit_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else if (in_bad)
                    begin
                        res_count_next  = sat_cnt(total_reg);
                        res_status_next = STAT_ERR;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                pos_next = seen_pos;
                if (chk_err)
                begin
                    res_count_next  = sat_cnt(total_reg);
                    res_status_next = STAT_ERR;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_EMIT;
                    if (is_append)
                    begin
                        loaded_next     = loaded_reg + CNT_W'(1);
                        total_next      = sum_tot;
                        res_count_next  = sat_cnt(sum_tot);
                        res_status_next = STAT_OK;
                    end
                    else if (scan_stat.key_present)
                    begin
                        total_next      = diff_tot;
                        res_count_next  = sat_cnt(total_reg);
                        res_status_next = STAT_OK;
                    end
                    else
                    begin
                        res_count_next  = sat_cnt(total_reg);
                        res_status_next = STAT_ERR;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_count_next  = res_count_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            loaded_reg   <= '0;
            total_reg    <= '0;
            sweep_reg    <= '0;
            clr_emit_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            total_reg    <= total_next;
            sweep_reg    <= sweep_next;
            clr_emit_reg <= clr_emit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_count_reg};
    assign m_tuser  = m_status_reg;

endmodule
